// ===== sv/bft_pkg.sv =====
// Types and fixed constants shared by the batch ticket FIFO files.
package bft_pkg;

  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 8;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int TICKET_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_POP  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_SKIP,
    S_READ,
    S_DONE
  } state_t;

  // strobes from the sequencer to the ring store
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } ring_req_t;

endpackage

// ===== sv/bft_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface bft_in_if;
  logic                            valid;
  logic                            ready;
  logic [bft_pkg::FUNC_W-1:0]      func;
  logic [bft_pkg::COUNT_W-1:0]     count;
  logic [bft_pkg::POS_W-1:0]       position;

  modport source (output valid, func, count, position, input ready);
  modport sink   (input valid, func, count, position, output ready);
endinterface

interface bft_out_if #(parameter int OCC_W = 5);
  logic                            valid;
  logic                            ready;
  logic [bft_pkg::STATUS_W-1:0]    status;
  logic [OCC_W-1:0]                occupancy;
  logic [bft_pkg::TICKET_W-1:0]    entry_value;

  modport source (output valid, status, occupancy, entry_value, input ready);
  modport sink   (input valid, status, occupancy, entry_value, output ready);
endinterface

// ===== sv/bft_ring.sv =====
// Ring store of ticket entries: one write port, one registered read port.
module bft_ring #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                          clk,
  input  bft_pkg::ring_req_t            req,
  input  logic [IDX_W-1:0]              waddr,
  input  logic [bft_pkg::TICKET_W-1:0]  wdata,
  input  logic [IDX_W-1:0]              raddr,
  output logic [bft_pkg::TICKET_W-1:0]  rdata
);

  logic [bft_pkg::TICKET_W-1:0] mem [DEPTH];
  logic [bft_pkg::TICKET_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/batch_ticket_fifo_top.sv =====
// Batch ticket FIFO: top level with operation sequencer and result register.
//
// A queue of up to DEPTH numbered clients. A push of n stamps each client
// with the next value of a 32-bit ticket counter and appends it; clients
// that do not fit are dropped but still consume ticket numbers, and the
// result reports overflow. A pop of n drops n front entries, or empties
// the queue and reports underflow if n exceeds the occupancy. A read
// returns the ticket at a position from the front, or 0 past the back.
// Every request gives exactly one result with the new occupancy. The block
// takes one request at a time: after its transfer a request passes the
// execute state; a push then has one write state per client appended,
// since the single write port of the ring stores one ticket per cycle,
// then a skip state; a read that hits has a registered memory read state;
// all end in the done state. A result still waiting in the output register
// holds the following request in its done state until the register frees,
// so it also delays the request transfer after that one.
module batch_ticket_fifo_top #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  bft_in_if.sink      in_ch,
  bft_out_if.source   out_ch
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int SUM_W = OCC_W + 1;
  localparam int N_W   = (OCC_W > bft_pkg::COUNT_W) ? OCC_W : bft_pkg::COUNT_W;
  localparam int CMP_W = (OCC_W > bft_pkg::POS_W) ? OCC_W : bft_pkg::POS_W;
  localparam int TW    = bft_pkg::TICKET_W;

  bft_pkg::state_t                state_r, state_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [OCC_W-1:0]               fill_r, fill_nxt;
  logic [TW-1:0]                  ctr_r, ctr_nxt;
  logic                           out_valid_r, out_valid_nxt;

  bft_pkg::func_t                 func_r, func_nxt;
  logic [bft_pkg::COUNT_W-1:0]    count_r, count_nxt;
  logic [bft_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [IDX_W-1:0]               tail_r, tail_nxt;
  logic [OCC_W-1:0]               remain_r, remain_nxt;
  logic [bft_pkg::COUNT_W-1:0]    skip_r, skip_nxt;
  bft_pkg::status_t               status_r, status_nxt;
  logic [TW-1:0]                  value_r, value_nxt;
  bft_pkg::status_t               out_status_r, out_status_nxt;
  logic [OCC_W-1:0]               out_occ_r, out_occ_nxt;
  logic [TW-1:0]                  out_value_r, out_value_nxt;

  // request decode
  logic [N_W-1:0]                 n_ext, fill_n, room_n, skip_w;
  logic [OCC_W-1:0]               room, take;
  logic                           over, underflow, hit;
  logic [CMP_W-1:0]               pos_ext;

  // shared ring index adder
  logic [IDX_W-1:0]               idx_a;
  logic [OCC_W-1:0]               idx_b;
  logic [SUM_W-1:0]               idx_raw;
  logic [IDX_W-1:0]               idx_sum;

  // shared ticket adder
  logic [TW-1:0]                  ctr_op, ctr_sum;

  bft_pkg::ring_req_t             ring_req;
  logic [IDX_W-1:0]               ring_raddr;
  logic [TW-1:0]                  ring_rdata;

  bft_ring #(.DEPTH(DEPTH), .IDX_W(IDX_W)) u_ring (
    .clk   (clk),
    .req   (ring_req),
    .waddr (tail_r),
    .wdata (ctr_sum),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  always_comb begin
    n_ext     = N_W'(count_r);
    fill_n    = N_W'(fill_r);
    room      = OCC_W'(DEPTH) - fill_r;
    room_n    = N_W'(room);
    over      = n_ext > room_n;
    take      = over ? room : n_ext[OCC_W-1:0];
    skip_w    = n_ext - N_W'(take);
    underflow = n_ext > fill_n;
    pos_ext   = CMP_W'(pos_r);
    hit       = pos_ext < CMP_W'(fill_r);
  end

  // operands of both shared adders follow the sequencer state
  always_comb begin
    if (state_r == bft_pkg::S_PUSH) begin
      idx_a = tail_r;
      idx_b = OCC_W'(1);
    end else begin
      idx_a = head_r;
      case (func_r)
        bft_pkg::FUNC_PUSH: idx_b = fill_r;
        bft_pkg::FUNC_POP:  idx_b = n_ext[OCC_W-1:0];
        default:            idx_b = pos_ext[OCC_W-1:0];
      endcase
    end
    // both operands stay below twice the depth: one conditional subtract
    idx_raw = SUM_W'(idx_a) + SUM_W'(idx_b);
    if (idx_raw >= SUM_W'(DEPTH)) begin
      idx_raw = idx_raw - SUM_W'(DEPTH);
    end
    idx_sum = idx_raw[IDX_W-1:0];

    ctr_op  = (state_r == bft_pkg::S_PUSH) ? TW'(1) : TW'(skip_r);
    ctr_sum = ctr_r + ctr_op;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    ctr_nxt        = ctr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    func_nxt       = func_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    tail_nxt       = tail_r;
    remain_nxt     = remain_r;
    skip_nxt       = skip_r;
    status_nxt     = status_r;
    value_nxt      = value_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    out_value_nxt  = out_value_r;
    ring_req       = '0;
    ring_raddr     = idx_sum;

    case (state_r)
      bft_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt  = bft_pkg::func_t'(in_ch.func);
          count_nxt = in_ch.count;
          pos_nxt   = in_ch.position;
          state_nxt = bft_pkg::S_EXEC;
        end
      end
      bft_pkg::S_EXEC: begin
        value_nxt  = '0;
        status_nxt = bft_pkg::ST_OK;
        state_nxt  = bft_pkg::S_DONE;
        case (func_r)
          bft_pkg::FUNC_PUSH: begin
            tail_nxt   = idx_sum;
            remain_nxt = take;
            skip_nxt   = skip_w[bft_pkg::COUNT_W-1:0];
            status_nxt = over ? bft_pkg::ST_OVERFLOW : bft_pkg::ST_OK;
            state_nxt  = (take == '0) ? bft_pkg::S_SKIP : bft_pkg::S_PUSH;
          end
          bft_pkg::FUNC_POP: begin
            if (underflow) begin
              fill_nxt   = '0;
              status_nxt = bft_pkg::ST_UNDERFLOW;
            end else begin
              head_nxt = idx_sum;
              fill_nxt = fill_r - n_ext[OCC_W-1:0];
            end
          end
          bft_pkg::FUNC_READ: begin
            if (hit) begin
              ring_req.rd_en = 1'b1;
              state_nxt      = bft_pkg::S_READ;
            end
          end
          default: begin
          end
        endcase
      end
      bft_pkg::S_PUSH: begin
        ring_req.wr_en = 1'b1;
        ctr_nxt        = ctr_sum;
        tail_nxt       = idx_sum;
        fill_nxt       = fill_r + OCC_W'(1);
        remain_nxt     = remain_r - OCC_W'(1);
        if (remain_r == OCC_W'(1)) begin
          state_nxt = bft_pkg::S_SKIP;
        end
      end
      bft_pkg::S_SKIP: begin
        // dropped clients still consume ticket numbers
        ctr_nxt   = ctr_sum;
        state_nxt = bft_pkg::S_DONE;
      end
      bft_pkg::S_READ: begin
        value_nxt = ring_rdata;
        state_nxt = bft_pkg::S_DONE;
      end
      bft_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_occ_nxt    = fill_r;
          out_value_nxt  = value_r;
          state_nxt      = bft_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bft_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bft_pkg::S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    count_r      <= count_nxt;
    pos_r        <= pos_nxt;
    tail_r       <= tail_nxt;
    remain_r     <= remain_nxt;
    skip_r       <= skip_nxt;
    status_r     <= status_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign in_ch.ready        = (state_r == bft_pkg::S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.occupancy   = out_occ_r;
  assign out_ch.entry_value = out_value_r;

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == bft_pkg::S_EXEC))
    else $error("request transfer did not start execution");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bft_pkg::S_PUSH) |-> (fill_r < OCC_W'(DEPTH)))
    else $error("ring write with queue full");

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= OCC_W'(DEPTH))
    else $error("occupancy beyond depth");

  a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bft_pkg::S_EXEC && func_r == bft_pkg::FUNC_POP && underflow)
    |=> (fill_r == '0 && status_r == bft_pkg::ST_UNDERFLOW))
    else $error("pop underflow did not empty queue");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bft_pkg::S_DONE && (!out_valid_r || out_ch.ready))
    |=> (out_valid_r && state_r == bft_pkg::S_IDLE))
    else $error("result not loaded into output register");

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the batch ticket FIFO: directed and random requests against a queue mirror.
`timescale 1ns / 100ps

module tb_top;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int TW        = bft_pkg::TICKET_W;
  localparam int CNT_W     = bft_pkg::COUNT_W;
  localparam int PW        = bft_pkg::POS_W;
  localparam int CLK_HALF  = 5;
  localparam int MAX_CYC   = 500_000;
  localparam int TAIL_CYC  = 40;

  typedef struct {
    bft_pkg::status_t     status;
    logic [OCC_W-1:0]     occupancy;
    logic [TW-1:0]        entry_value;
  } ticket_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  bft_in_if                    in_ch();
  bft_out_if #(.OCC_W(OCC_W))  out_ch();

  batch_ticket_fifo_top #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // mirror of the queue
  logic [TW-1:0]       ring [DEPTH];
  int                  head;
  int                  fill;
  logic [TW-1:0]       tickets;

  ticket_reply_t ticket_replies_q[$];

  bit idle_en;
  int err_cnt;
  int n_sent, n_overflow, n_underflow, n_read_hit, n_checked;
  int stall_left;

  function automatic ticket_reply_t compute_ticket_reply(bft_pkg::func_t f,
                                                         logic [CNT_W-1:0] n,
                                                         logic [PW-1:0] p);
    ticket_reply_t r;
    int room;
    int take;
    r.status      = bft_pkg::ST_OK;
    r.entry_value = '0;
    case (f)
      bft_pkg::FUNC_PUSH: begin
        room = DEPTH - fill;
        take = (int'(n) > room) ? room : int'(n);
        if (int'(n) > room) begin
          r.status = bft_pkg::ST_OVERFLOW;
          n_overflow++;
        end
        for (int k = 0; k < take; k++) begin
          tickets = tickets + TW'(1);
          ring[IDX_W'((head + fill) % DEPTH)] = tickets;
          fill++;
        end
        // clients that did not fit still use up ticket numbers
        tickets = tickets + TW'(int'(n) - take);
      end
      bft_pkg::FUNC_POP: begin
        if (int'(n) > fill) begin
          fill = 0;
          r.status = bft_pkg::ST_UNDERFLOW;
          n_underflow++;
        end else begin
          head = (head + int'(n)) % DEPTH;
          fill = fill - int'(n);
        end
      end
      bft_pkg::FUNC_READ: begin
        if (int'(p) < fill) begin
          r.entry_value = ring[IDX_W'((head + int'(p)) % DEPTH)];
          n_read_hit++;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(fill);
    return r;
  endfunction

  // one request; returns at the edge of its transfer
  task automatic send_op(bft_pkg::func_t f, logic [CNT_W-1:0] n, logic [PW-1:0] p);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= f;
    in_ch.count    <= n;
    in_ch.position <= p;
    do @(posedge clk); while (!in_ch.ready);
    ticket_replies_q.push_back(compute_ticket_reply(f, n, p));
    n_sent++;
  endtask

  task automatic wait_replies_done();
    in_ch.valid <= 1'b0;
    while (ticket_replies_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall bursts, check each transfer against the oldest reply
  always @(posedge clk) begin
    ticket_reply_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (ticket_replies_q.size() == 0) begin
          $error("result with no request pending: status %0d occupancy %0d entry_value %0d",
                 out_ch.status, out_ch.occupancy, out_ch.entry_value);
          err_cnt++;
        end else begin
          want = ticket_replies_q.pop_front();
          n_checked++;
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            err_cnt++;
          end
          if (out_ch.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", want.occupancy, out_ch.occupancy);
            err_cnt++;
          end
          if (out_ch.entry_value !== want.entry_value) begin
            $error("entry_value: expected %0d, actual %0d", want.entry_value,
                   out_ch.entry_value);
            err_cnt++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_edge_cases();
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd0);      // read of empty queue
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd15);
    send_op(bft_pkg::FUNC_POP, 8'd0, 4'd0);       // pop of zero
    send_op(bft_pkg::FUNC_POP, 8'd1, 4'd0);       // underflow on empty
    send_op(bft_pkg::FUNC_PUSH, 8'd0, 4'd0);      // push of zero
    send_op(bft_pkg::FUNC_PUSH, 8'd1, 4'd0);
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd0);
    send_op(bft_pkg::FUNC_PUSH, 8'd15, 4'd0);     // exactly full
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd15);
    send_op(bft_pkg::FUNC_PUSH, 8'd1, 4'd0);      // overflow by one
    send_op(bft_pkg::FUNC_PUSH, 8'd255, 4'd0);    // overflow while full, max count
    send_op(bft_pkg::FUNC_NOP, 8'd255, 4'd15);
    send_op(bft_pkg::FUNC_POP, 8'd3, 4'd0);
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd12);     // last entry
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd13);     // just past the back
    send_op(bft_pkg::FUNC_POP, 8'd13, 4'd0);      // exact drain
    send_op(bft_pkg::FUNC_PUSH, 8'd200, 4'd0);    // overflow from empty
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd0);
    send_op(bft_pkg::FUNC_POP, 8'd255, 4'd0);
    send_op(bft_pkg::FUNC_PUSH, 8'd5, 4'd0);
    send_op(bft_pkg::FUNC_POP, 8'd6, 4'd0);       // underflow keeps head
    send_op(bft_pkg::FUNC_PUSH, 8'd3, 4'd0);
    send_op(bft_pkg::FUNC_READ, 8'd0, 4'd2);
    send_op(bft_pkg::FUNC_NOP, 8'd0, 4'd0);
    send_op(bft_pkg::FUNC_POP, 8'd2, 4'd0);
  endtask

  task automatic test_random_traffic(int n_items);
    int  r;
    int  room;
    logic [CNT_W-1:0] n;
    logic [PW-1:0]    p;
    for (int i = 0; i < n_items; i++) begin
      r    = $urandom_range(0, 99);
      room = DEPTH - fill;
      p    = PW'($urandom_range(0, DEPTH - 1));
      n    = CNT_W'($urandom_range(0, 255));
      if (r < 40) begin
        r = $urandom_range(0, 99);
        if (r < 60)      n = (room > 0) ? CNT_W'($urandom_range(1, room)) : '0;
        else if (r < 85) n = CNT_W'($urandom_range(0, 20));
        if (r < 98 && int'(n) > room + 4) n = CNT_W'($urandom_range(0, room + 4));
        send_op(bft_pkg::FUNC_PUSH, n, p);
      end else if (r < 70) begin
        r = $urandom_range(0, 99);
        if (r < 75)      n = CNT_W'($urandom_range(0, fill));
        else if (r < 95) n = CNT_W'($urandom_range(fill + 1, fill + 4));
        send_op(bft_pkg::FUNC_POP, n, p);
      end else if (r < 95) begin
        if (fill > 0 && $urandom_range(0, 4) != 0) p = PW'($urandom_range(0, fill - 1));
        send_op(bft_pkg::FUNC_READ, n, p);
      end else begin
        send_op(bft_pkg::FUNC_NOP, n, p);
      end
    end
  endtask

  // sender holds off until the queue of replies has drained, several times
  task automatic test_drain_between_bursts(int n_bursts, int burst_len);
    for (int b = 0; b < n_bursts; b++) begin
      test_random_traffic(burst_len);
      wait_replies_done();
      @(posedge clk);
    end
  endtask

  task automatic test_back_to_back(int n_items);
    idle_en = 1'b0;
    test_random_traffic(n_items);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.func     = bft_pkg::FUNC_NOP;
    in_ch.count    = '0;
    in_ch.position = '0;
    head    = 0;
    fill    = 0;
    tickets = '0;
    idle_en = 1'b1;
    err_cnt = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_cases();
    test_random_traffic(900);
    test_drain_between_bursts(5, 80);
    test_back_to_back(250);

    wait_replies_done();
    repeat (TAIL_CYC) @(posedge clk);

    $display("Sent %0d requests, checked %0d replies.", n_sent, n_checked);
    $display("Overflows %0d, underflows %0d, read hits %0d, last ticket %0d.",
             n_overflow, n_underflow, n_read_hit, tickets);
    if (err_cnt == 0 && ticket_replies_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    repeat (MAX_CYC) @(posedge clk);
    $display("Timeout with %0d replies outstanding.", ticket_replies_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/bft_pkg.sv
sv/bft_if.sv
sv/bft_ring.sv
sv/batch_ticket_fifo_top.sv
verif/tb_top.sv
